### rtl/gbn_pkg.sv
// Shared types and constants of the greedy box NMS unit.
// Depends on nothing; every other file but gbn_ram imports it.
`default_nettype none
package gbn_pkg;

  // Default sizes of the kept-box store and the box index range.
  localparam int DEF_MAX_KEEP  = 64;
  localparam int DEF_MAX_BOXES = 65536;

  // One pixel in unsigned Q12.4, for the inclusive corner convention.
  localparam int PIX_ONE = 16;

  // Field widths fixed by the item format.
  localparam int CoordW = 16;
  localparam int BoxW   = 4 * CoordW;
  localparam int IdxW   = 16;
  localparam int CntW   = 7;
  localparam int ThrW   = 16;

  // Configuration port.
  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] REG_IOU_THRESHOLD = 1'd0;
  localparam logic [CfgAddrW-1:0] REG_MAX_KEEPS     = 1'd1;
  localparam logic [ThrW-1:0] THR_RESET = 16'd45875;
  localparam logic [CntW-1:0] MK_RESET  = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the incoming box
    logic load_area;  // compute the area of the latched box
    logic clr_hit;    // clear the suppression flag
    logic issue;      // read one kept entry into the compare pipeline
    logic wr_en;      // store the latched box as a kept entry
  } gbn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // some compared kept box suppresses this one
    logic pipe_busy;  // compare pipeline still holds an entry
    logic last;       // latched box closes its set
  } gbn_status_t;

endpackage
`default_nettype wire

### rtl/gbn_box_if.sv
// Input channel of the greedy box NMS unit: one box per item.
// Depends on gbn_pkg for field widths.
`default_nettype none
interface gbn_box_if;
  import gbn_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] x_min;
  logic [CoordW-1:0] y_min;
  logic [CoordW-1:0] x_max;
  logic [CoordW-1:0] y_max;
  logic              last_box;

  modport source (output valid, x_min, y_min, x_max, y_max, last_box, input ready);
  modport sink   (input valid, x_min, y_min, x_max, y_max, last_box, output ready);
endinterface
`default_nettype wire

### rtl/gbn_result_if.sv
// Result channel of the greedy box NMS unit: one decision per item.
// Depends on gbn_pkg for field widths.
`default_nettype none
interface gbn_result_if;
  import gbn_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] box_index;
  logic            kept;
  logic [CntW-1:0] kept_count;
  logic            set_done;

  modport source (output valid, box_index, kept, kept_count, set_done, input ready);
  modport sink   (input valid, box_index, kept, kept_count, set_done, output ready);
endinterface
`default_nettype wire

### rtl/gbn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module gbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/gbn_datapath.sv
// Datapath of the greedy box NMS unit: box register, kept-box store and
// the pipelined IoU compare. Depends on gbn_pkg and gbn_ram.
`default_nettype none
module gbn_datapath #(
  parameter int MAX_KEEP = gbn_pkg::DEF_MAX_KEEP,
  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gbn_pkg::gbn_cmd_t         cmd,
  input  wire logic [AW-1:0]             rd_addr,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [gbn_pkg::ThrW-1:0]  thr,
  input  wire logic [gbn_pkg::CoordW-1:0] x_min,
  input  wire logic [gbn_pkg::CoordW-1:0] y_min,
  input  wire logic [gbn_pkg::CoordW-1:0] x_max,
  input  wire logic [gbn_pkg::CoordW-1:0] y_max,
  input  wire logic                      last_box,
  output gbn_pkg::gbn_status_t           status
);
  import gbn_pkg::*;

  localparam logic signed [17:0] ONE_PIX = 18'(PIX_ONE);

  // Latched box, packed x_min | y_min | x_max | y_max from the low end.
  logic [BoxW-1:0] box_r;
  logic            last_r;
  logic signed [35:0] area_new_r;

  // Pipeline valid bits.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [BoxW-1:0] rdata;

  // Stage 2 registers.
  logic               disj2_r;
  logic        [16:0] w2_r, h2_r;
  logic signed [17:0] ew2_r, eh2_r;
  // Stage 3 registers.
  logic               disj3_r;
  logic        [33:0] inter3_r;
  logic signed [35:0] area3_r;
  // Stage 4 registers.
  logic               disj4_r;
  logic        [33:0] inter4_r;
  logic signed [37:0] uni4_r;
  // Stage 5 registers.
  logic               disj5_r;
  logic               upos5_r;
  logic signed [55:0] lhs5_r;
  logic signed [55:0] rhs5_r;
  logic               hit_r;

  // Kept-box store.
  gbn_ram #(.WIDTH(BoxW), .DEPTH(MAX_KEEP)) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (box_r),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Corners of the stored box (a) and the new box (b).
  logic [CoordW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic [CoordW-1:0] ix0, iy0, ix1, iy1;
  logic signed [17:0] w_raw, h_raw, ew, eh, nw, nh;
  logic disj;

  always_comb begin
    ax0 = rdata[15:0];
    ay0 = rdata[31:16];
    ax1 = rdata[47:32];
    ay1 = rdata[63:48];
    bx0 = box_r[15:0];
    by0 = box_r[31:16];
    bx1 = box_r[47:32];
    by1 = box_r[63:48];
    disj = (ax0 > bx1) || (ay0 > by1) || (ax1 < bx0) || (ay1 < by0);
    ix0 = (ax0 > bx0) ? ax0 : bx0;
    iy0 = (ay0 > by0) ? ay0 : by0;
    ix1 = (ax1 < bx1) ? ax1 : bx1;
    iy1 = (ay1 < by1) ? ay1 : by1;
    w_raw = $signed({2'b00, ix1}) - $signed({2'b00, ix0}) + ONE_PIX;
    h_raw = $signed({2'b00, iy1}) - $signed({2'b00, iy0}) + ONE_PIX;
    ew = $signed({2'b00, ax1}) - $signed({2'b00, ax0}) + ONE_PIX;
    eh = $signed({2'b00, ay1}) - $signed({2'b00, ay0}) + ONE_PIX;
    nw = $signed({2'b00, bx1}) - $signed({2'b00, bx0}) + ONE_PIX;
    nh = $signed({2'b00, by1}) - $signed({2'b00, by0}) + ONE_PIX;
  end

  // Pipeline valid bits and the suppression flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (cmd.clr_hit) begin
        hit_r <= 1'b0;
      end else if (v5_r && !disj5_r && upos5_r && (lhs5_r > rhs5_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Box register and the area of the new box.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_r  <= {y_max, x_max, y_min, x_min};
      last_r <= last_box;
    end
    if (cmd.load_area) begin
      area_new_r <= nw * nh;
    end
  end

  // Compare pipeline payload: extents, products, union, threshold product.
  always_ff @(posedge clk) begin
    disj2_r  <= disj;
    w2_r     <= w_raw[17] ? 17'd0 : w_raw[16:0];
    h2_r     <= h_raw[17] ? 17'd0 : h_raw[16:0];
    ew2_r    <= ew;
    eh2_r    <= eh;

    disj3_r  <= disj2_r;
    inter3_r <= w2_r * h2_r;
    area3_r  <= ew2_r * eh2_r;

    disj4_r  <= disj3_r;
    inter4_r <= inter3_r;
    uni4_r   <= 38'(area_new_r) + 38'(area3_r) - $signed({4'b0000, inter3_r});

    disj5_r  <= disj4_r;
    upos5_r  <= (uni4_r > 38'sd0);
    lhs5_r   <= $signed({6'b000000, inter4_r, 16'h0000});
    rhs5_r   <= 56'($signed({1'b0, thr}) * uni4_r);
  end

  assign status.hit       = hit_r;
  assign status.pipe_busy = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign status.last      = last_r;

`ifndef NO_ASSERTIONS
  // A clear always leaves the flag low on the next cycle.
  a_clr_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_hit |=> !hit_r)
    else $error("suppression flag not cleared");
  // The flag only rises when a compare leaves the pipeline.
  a_hit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hit_r) |-> $past(v5_r))
    else $error("suppression flag rose without a compare");
  // No read while a write lands in the store.
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.issue && cmd.wr_en))
    else $error("store read and write in one cycle");
`endif

endmodule
`default_nettype wire

### rtl/gbn_ctrl.sv
// Controller of the greedy box NMS unit: sequencer, set counters,
// configuration registers and the result register. Depends on gbn_pkg.
`default_nettype none
module gbn_ctrl #(
  parameter int MAX_KEEP  = gbn_pkg::DEF_MAX_KEEP,
  parameter int MAX_BOXES = gbn_pkg::DEF_MAX_BOXES,
  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1,
  localparam int KW = $clog2(MAX_KEEP + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [gbn_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [gbn_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [gbn_pkg::IdxW-1:0]         out_box_index,
  output logic                             out_kept,
  output logic [gbn_pkg::CntW-1:0]         out_kept_count,
  output logic                             out_set_done,
  output gbn_pkg::gbn_cmd_t                cmd,
  output logic [AW-1:0]                    rd_addr,
  output logic [AW-1:0]                    wr_addr,
  output logic [gbn_pkg::ThrW-1:0]         thr,
  input  wire gbn_pkg::gbn_status_t        status
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_DRAIN, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [KW-1:0]   kept_total_r, kept_total_nxt;
  logic [IdxW-1:0] box_counter_r, box_counter_nxt;
  logic [IdxW-1:0] index_r, index_nxt;
  logic [AW-1:0]   scan_r, scan_nxt;
  logic            keep_r, keep_nxt;
  logic [ThrW-1:0] thr_r;
  logic [CntW-1:0] mk_r;
  logic            out_valid_r, out_valid_nxt;
  logic [IdxW-1:0] out_index_r, out_index_nxt;
  logic            out_kept_r, out_kept_nxt;
  logic [CntW-1:0] out_count_r, out_count_nxt;
  logic            out_done_r, out_done_nxt;

  logic [KW-1:0] limit;
  logic          accept;
  logic          slot_free;
  logic [KW-1:0] total_inc;

  // Effective keep limit.
  always_comb begin
    if ((mk_r == '0) || (int'(mk_r) > MAX_KEEP)) begin
      limit = KW'(MAX_KEEP);
    end else begin
      limit = KW'(mk_r);
    end
  end

  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign total_inc = kept_total_r + KW'(1);

  // Next state, commands and result values.
  always_comb begin
    state_nxt       = state_r;
    kept_total_nxt  = kept_total_r;
    box_counter_nxt = box_counter_r;
    index_nxt       = index_r;
    scan_nxt        = scan_r;
    keep_nxt        = keep_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_index_nxt   = out_index_r;
    out_kept_nxt    = out_kept_r;
    out_count_nxt   = out_count_r;
    out_done_nxt    = out_done_r;
    cmd             = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          index_nxt = box_counter_r;
          scan_nxt  = '0;
          keep_nxt  = (kept_total_r < limit);
          if ((kept_total_r >= limit) || (kept_total_r == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.load_area = 1'b1;
        cmd.clr_hit   = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        scan_nxt  = scan_r + AW'(1);
        if (KW'(scan_r) == kept_total_r - KW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          keep_nxt  = !status.hit;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.wr_en     = keep_r;
          out_valid_nxt = 1'b1;
          out_index_nxt = index_r;
          out_kept_nxt  = keep_r;
          out_count_nxt = keep_r ? CntW'(total_inc) : CntW'(kept_total_r);
          out_done_nxt  = status.last;
          if (keep_r) begin
            kept_total_nxt = total_inc;
          end
          if (box_counter_r < IdxW'(MAX_BOXES - 1)) begin
            box_counter_nxt = box_counter_r + IdxW'(1);
          end
          if (status.last) begin
            kept_total_nxt  = '0;
            box_counter_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      kept_total_r  <= '0;
      box_counter_r <= '0;
      out_valid_r   <= 1'b0;
      thr_r         <= THR_RESET;
      mk_r          <= MK_RESET;
    end else begin
      state_r       <= state_nxt;
      kept_total_r  <= kept_total_nxt;
      box_counter_r <= box_counter_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_IOU_THRESHOLD: thr_r <= cfg_wdata[ThrW-1:0];
          REG_MAX_KEEPS:     mk_r  <= cfg_wdata[CntW-1:0];
          default: ;
        endcase
      end
    end
    index_r     <= index_nxt;
    scan_r      <= scan_nxt;
    keep_r      <= keep_nxt;
    out_index_r <= out_index_nxt;
    out_kept_r  <= out_kept_nxt;
    out_count_r <= out_count_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_box_index  = out_index_r;
  assign out_kept       = out_kept_r;
  assign out_kept_count = out_count_r;
  assign out_set_done   = out_done_r;
  assign rd_addr        = scan_r;
  assign wr_addr        = kept_total_r[AW-1:0];
  assign thr            = thr_r;

`ifndef NO_ASSERTIONS
  // The kept count never passes the store depth.
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    kept_total_r <= KW'(MAX_KEEP))
    else $error("kept count beyond store depth");
  // Reads only touch entries written in this set.
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (KW'(rd_addr) < kept_total_r))
    else $error("read of an unwritten entry");
  // A store write advances the count or closes the set.
  a_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |=> (kept_total_r == $past(total_inc)) || (kept_total_r == '0))
    else $error("kept count not advanced on store write");
`endif

endmodule
`default_nettype wire

### rtl/greedy_box_nms_unit.sv
// Greedy box NMS: with k boxes kept so far in the set, an item reads the k
// kept boxes from the kept-box store into a five-stage IoU compare pipeline;
// it skips the compare when k is 0 or the keep limit is reached. One item is
// in work at a time; the result register lets the next item enter while a
// result waits. Synchronous active-low reset clears control state and
// restores the register defaults; no clearing pass.
`default_nettype none
module greedy_box_nms_unit #(
  parameter int MAX_KEEP  = gbn_pkg::DEF_MAX_KEEP,
  parameter int MAX_BOXES = gbn_pkg::DEF_MAX_BOXES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [gbn_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [gbn_pkg::CfgDataW-1:0] cfg_wdata,
  gbn_box_if.sink                           in_box,
  gbn_result_if.source                      out_res
);
  import gbn_pkg::*;

  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  gbn_cmd_t        cmd;
  gbn_status_t     status;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [ThrW-1:0] thr;

  // Sequencer and result register.
  gbn_ctrl #(.MAX_KEEP(MAX_KEEP), .MAX_BOXES(MAX_BOXES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_box.valid),
    .in_ready       (in_box.ready),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_box_index  (out_res.box_index),
    .out_kept       (out_res.kept),
    .out_kept_count (out_res.kept_count),
    .out_set_done   (out_res.set_done),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .thr            (thr),
    .status         (status)
  );

  // Store and IoU compare.
  gbn_datapath #(.MAX_KEEP(MAX_KEEP)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .thr      (thr),
    .x_min    (in_box.x_min),
    .y_min    (in_box.y_min),
    .x_max    (in_box.x_max),
    .y_max    (in_box.y_max),
    .last_box (in_box.last_box),
    .status   (status)
  );

endmodule
`default_nettype wire
